// ----- rtl/core/fspa_pkg.sv -----
// Shared constants, codes and control types of the fixed slot pool allocator.
`timescale 1ns / 1ps
package fspa_pkg;

  // Built depth of the pool
  localparam int unsigned MaxSlotsDefault = 1024;

  // Field widths of request and response items and of the capacity register
  localparam int unsigned KIND_W = 2;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned TYPE_W = 64;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned CAP_W  = 11;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INSPECT = 2'd2;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_SLOT_BYTES   = 1'b0;
  localparam logic REG_SLOTS_IN_USE = 1'b1;
  localparam logic [LEN_W-1:0] SLOT_BYTES_RST   = 32'd64;
  localparam logic [CAP_W-1:0] SLOTS_IN_USE_RST = 11'd1024;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the item and launch the memory reads
    logic commit;   // update state, write memories, load the result
  } fspa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_full;  // result register holds an item not yet taken
  } fspa_status_t;

endpackage

// ----- rtl/core/fspa_if.sv -----
// Request and response channel interfaces of the fixed slot pool allocator.
`timescale 1ns / 1ps
interface fspa_req_if;
  logic                        valid;
  logic                        ready;
  logic [fspa_pkg::KIND_W-1:0] kind;
  logic [fspa_pkg::IDX_W-1:0]  slot_index;
  logic [fspa_pkg::TYPE_W-1:0] new_type;

  modport source (output valid, output kind, output slot_index, output new_type,
                  input ready);
  modport sink (input valid, input kind, input slot_index, input new_type,
                output ready);
endinterface

interface fspa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [fspa_pkg::IDX_W-1:0]  granted_slot;
  logic [fspa_pkg::TYPE_W-1:0] slot_type;
  logic [fspa_pkg::LEN_W-1:0]  slot_length;

  modport source (output valid, output ok, output granted_slot, output slot_type,
                  output slot_length, input ready);
  modport sink (input valid, input ok, input granted_slot, input slot_type,
                input slot_length, output ready);
endinterface

// ----- rtl/core/fspa_regs.sv -----
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module fspa_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fspa_pkg::PADDR_W-1:0]  paddr,
  input  logic [fspa_pkg::PDATA_W-1:0]  pwdata,
  output logic [fspa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [fspa_pkg::LEN_W-1:0]    slot_bytes_o,
  output logic [fspa_pkg::CAP_W-1:0]    slots_in_use_o
);
  import fspa_pkg::*;

  logic             reg_sel;
  logic             wr_en;
  logic [LEN_W-1:0] slot_bytes_q;
  logic [CAP_W-1:0] slots_in_use_q;

  // Decode the register by its word address
  assign reg_sel = paddr[PADDR_W-1];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Write the selected register in the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_bytes_q   <= SLOT_BYTES_RST;
      slots_in_use_q <= SLOTS_IN_USE_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SLOT_BYTES:   slot_bytes_q   <= pwdata[LEN_W-1:0];
        REG_SLOTS_IN_USE: slots_in_use_q <= pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the selected register on reads
  always_comb begin
    case (reg_sel)
      REG_SLOT_BYTES:   prdata = PDATA_W'(slot_bytes_q);
      REG_SLOTS_IN_USE: prdata = PDATA_W'(slots_in_use_q);
      default:          prdata = '0;
    endcase
  end

  assign slot_bytes_o   = slot_bytes_q;
  assign slots_in_use_o = slots_in_use_q;

endmodule

// ----- rtl/core/fspa_ctrl.sv -----
// Controller: sequences each item through capture and commit.
`timescale 1ns / 1ps
module fspa_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    out_ready_i,
  input  fspa_pkg::fspa_status_t  status_i,
  output fspa_pkg::fspa_cmd_t     cmd_o
);
  import fspa_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   commit;

  // Commit once the result register is free or being emptied
  assign commit = (state_q == ST_EXEC) & (~status_i.out_full | out_ready_i);

  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.capture = (state_q == ST_IDLE) & in_valid_i;
  assign cmd_o.commit  = commit;

  // Advance from capture to commit and back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (commit) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/fspa_dp.sv -----
// Datapath: slot memories, free list head, fresh counter and result register.
`timescale 1ns / 1ps
module fspa_dp #(
  parameter int unsigned MaxSlots = fspa_pkg::MaxSlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fspa_pkg::fspa_cmd_t           cmd_i,
  output fspa_pkg::fspa_status_t        status_o,
  input  logic [fspa_pkg::KIND_W-1:0]   kind_i,
  input  logic [fspa_pkg::IDX_W-1:0]    slot_index_i,
  input  logic [fspa_pkg::TYPE_W-1:0]   new_type_i,
  input  logic [fspa_pkg::LEN_W-1:0]    slot_bytes_i,
  input  logic [fspa_pkg::CAP_W-1:0]    slots_in_use_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          ok_o,
  output logic [fspa_pkg::IDX_W-1:0]    granted_slot_o,
  output logic [fspa_pkg::TYPE_W-1:0]   slot_type_o,
  output logic [fspa_pkg::LEN_W-1:0]    slot_length_o
);
  import fspa_pkg::*;

  // Address, pointer (with empty marker) and compare widths
  localparam int unsigned AW = $clog2(MaxSlots);
  localparam int unsigned PW = $clog2(MaxSlots + 1);
  localparam int unsigned CW = (PW > CAP_W) ? PW : CAP_W;
  localparam logic [PW-1:0] EmptyMark = PW'(MaxSlots);
  localparam logic [CW-1:0] MaxSlotsCw = CW'(MaxSlots);

  // Per-slot memories
  logic [TYPE_W-1:0] type_mem [MaxSlots];
  logic [PW-1:0]     link_mem [MaxSlots];
  logic              mark_mem [MaxSlots];

  // Captured item
  logic [KIND_W-1:0] kind_q;
  logic [CW-1:0]     idx_q;
  logic [TYPE_W-1:0] type_q;

  // Registered read data
  logic [TYPE_W-1:0] rd_type_q;
  logic [PW-1:0]     rd_link_q;
  logic              rd_mark_q;

  // Allocator state
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] fresh_q, fresh_d;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic              ok_q, ok_d;
  logic [IDX_W-1:0]  granted_q, granted_d;
  logic [TYPE_W-1:0] rtype_q, rtype_d;
  logic [LEN_W-1:0]  rlen_q, rlen_d;

  // Memory write controls
  logic              type_we, link_we, mark_we;
  logic [AW-1:0]     waddr;
  logic [TYPE_W-1:0] type_wdata;
  logic              mark_wdata;

  logic [CW-1:0] siu_cw, cap, fresh_cw, idx_in_cw;
  logic [AW-1:0] in_addr;
  logic [PW-1:0] slot;
  logic          grant;

  // Clamp the configured capacity to the built depth
  assign siu_cw    = CW'(slots_in_use_i);
  assign cap       = (siu_cw > MaxSlotsCw) ? MaxSlotsCw : siu_cw;
  assign fresh_cw  = CW'(fresh_q);
  assign idx_in_cw = CW'(slot_index_i);
  assign in_addr   = idx_in_cw[AW-1:0];

  // Latch the item on capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      idx_q  <= idx_in_cw;
      type_q <= new_type_i;
    end
  end

  // Type memory: read on capture, write on commit
  always_ff @(posedge clk_i) begin
    if (type_we) type_mem[waddr] <= type_wdata;
    if (cmd_i.capture) rd_type_q <= type_mem[in_addr];
  end

  // Link memory: read the successor of the list head on capture
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[waddr] <= head_q;
    if (cmd_i.capture) rd_link_q <= link_mem[head_q[AW-1:0]];
  end

  // Free mark memory
  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[waddr] <= mark_wdata;
    if (cmd_i.capture) rd_mark_q <= mark_mem[in_addr];
  end

  // Execute the captured item on commit
  always_comb begin
    head_d     = head_q;
    fresh_d    = fresh_q;
    type_we    = 1'b0;
    link_we    = 1'b0;
    mark_we    = 1'b0;
    waddr      = idx_q[AW-1:0];
    type_wdata = '0;
    mark_wdata = 1'b0;
    slot       = EmptyMark;
    grant      = 1'b0;
    ok_d       = ok_q;
    granted_d  = granted_q;
    rtype_d    = rtype_q;
    rlen_d     = rlen_q;
    if (cmd_i.commit) begin
      ok_d      = 1'b0;
      granted_d = '0;
      rtype_d   = '0;
      rlen_d    = '0;
      case (kind_q)
        KIND_ALLOC: begin
          // Pop the free list first, else take the next never-used slot
          if (head_q < EmptyMark) begin
            slot   = head_q;
            head_d = (rd_link_q > EmptyMark) ? EmptyMark : rd_link_q;
            grant  = 1'b1;
          end else if (fresh_cw < cap) begin
            slot    = fresh_q;
            fresh_d = PW'(fresh_q + 1'b1);
            grant   = 1'b1;
          end
          if (grant) begin
            waddr      = slot[AW-1:0];
            type_we    = 1'b1;
            type_wdata = type_q;
            mark_we    = 1'b1;
            mark_wdata = 1'b0;
            ok_d       = 1'b1;
            granted_d  = IDX_W'(CW'(slot));
          end
        end
        KIND_FREE: begin
          // Push a live slot; drop bad or double frees
          if ((idx_q < cap) && (idx_q < fresh_cw) && !rd_mark_q) begin
            type_we    = 1'b1;
            type_wdata = '0;
            mark_we    = 1'b1;
            mark_wdata = 1'b1;
            link_we    = 1'b1;
            head_d     = idx_q[PW-1:0];
            ok_d       = 1'b1;
          end
        end
        KIND_INSPECT: begin
          if (idx_q < cap) begin
            ok_d = 1'b1;
            if (idx_q < fresh_cw) begin
              rtype_d = rd_type_q;
              rlen_d  = slot_bytes_i;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= EmptyMark;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    ok_q      <= ok_d;
    granted_q <= granted_d;
    rtype_q   <= rtype_d;
    rlen_q    <= rlen_d;
  end

  assign status_o.out_full = out_valid_q;
  assign out_valid_o       = out_valid_q;
  assign ok_o              = ok_q;
  assign granted_slot_o    = granted_q;
  assign slot_type_o       = rtype_q;
  assign slot_length_o     = rlen_q;

endmodule

// ----- rtl/core/fixed_slot_pool_allocator_core.sv -----
// Fixed slot pool allocator: an item is taken in the cycle it is accepted, the slot
// memories are read at that edge, and in the commit state the free list head, the
// fresh counter and the memories are updated and the result register is loaded. A new
// item is accepted only once the one ahead of it is committed, since each item reads
// the slot memories and then writes them back. A finished result waits in its
// register while the next item is accepted; that item holds in its commit state
// until the result ahead of it is taken. The slot memories need no clearing after
// reset: only values of slots that were handed out at least once are ever used.
`timescale 1ns / 1ps
module fixed_slot_pool_allocator_core #(
  parameter int unsigned MaxSlots = fspa_pkg::MaxSlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fspa_req_if.sink                      req_i,
  fspa_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fspa_pkg::PADDR_W-1:0]  paddr,
  input  logic [fspa_pkg::PDATA_W-1:0]  pwdata,
  output logic [fspa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import fspa_pkg::*;

  fspa_cmd_t        cmd;
  fspa_status_t     status;
  logic [LEN_W-1:0] slot_bytes;
  logic [CAP_W-1:0] slots_in_use;

  // Configuration registers
  fspa_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .slot_bytes_o   (slot_bytes),
    .slots_in_use_o (slots_in_use)
  );

  // Sequencer
  fspa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Memories and allocator state
  fspa_dp #(
    .MaxSlots (MaxSlots)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_i         (req_i.kind),
    .slot_index_i   (req_i.slot_index),
    .new_type_i     (req_i.new_type),
    .slot_bytes_i   (slot_bytes),
    .slots_in_use_i (slots_in_use),
    .out_ready_i    (rsp_o.ready),
    .out_valid_o    (rsp_o.valid),
    .ok_o           (rsp_o.ok),
    .granted_slot_o (rsp_o.granted_slot),
    .slot_type_o    (rsp_o.slot_type),
    .slot_length_o  (rsp_o.slot_length)
  );

endmodule

// ----- rtl/core/fspa_checker.sv -----
// Port-level assertions for the fixed slot pool allocator, bound to the top level.
`timescale 1ns / 1ps
module fspa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic                         rsp_ok_i,
  input logic [fspa_pkg::IDX_W-1:0]   rsp_granted_slot_i,
  input logic [fspa_pkg::TYPE_W-1:0]  rsp_slot_type_i,
  input logic [fspa_pkg::LEN_W-1:0]   rsp_slot_length_i
);
  import fspa_pkg::*;

  // Stalled result keeps its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_ok_i) && $stable(rsp_granted_slot_i)
      && $stable(rsp_slot_type_i) && $stable(rsp_slot_length_i))
    else $error("result changed while stalled");

  // One item at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while previous item in flight");

  // A new result follows a cycle in which the block was busy
  a_rsp_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("result appeared without an item in flight");

  // A failed item reports all fields zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ok_i |->
      rsp_granted_slot_i == '0 && rsp_slot_type_i == '0 && rsp_slot_length_i == '0)
    else $error("failed result carries nonzero fields");

endmodule

bind fixed_slot_pool_allocator_core fspa_checker u_fspa_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_ok_i           (rsp_o.ok),
  .rsp_granted_slot_i (rsp_o.granted_slot),
  .rsp_slot_type_i    (rsp_o.slot_type),
  .rsp_slot_length_i  (rsp_o.slot_length)
);
